### design/slbs_pkg.sv
// ----------------------------------------------------------------------------
// slbs_pkg: shared types and constants for the status LED breathe sequencer
// Beat payload structs, color codes, link status codes and breathe constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slbs_pkg;

    localparam int TIME_W     = 32;
    localparam int LEVEL_W    = 10;
    localparam int STEP_W     = 8;
    localparam int INTERVAL_W = 10;
    localparam int TIMEOUT_W  = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_INDEX_W = 1;

    localparam int RAINBOW_MS_DEFAULT = 1000;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_BREATHE_INTERVAL = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ADV_TIMEOUT      = 1'b1;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET    = 10'd10;
    localparam logic [TIMEOUT_W-1:0]  ADV_TIMEOUT_RESET = 20'd30000;

    // color codes
    localparam logic [2:0] CLR_RED    = 3'd0;
    localparam logic [2:0] CLR_PURPLE = 3'd1;
    localparam logic [2:0] CLR_YELLOW = 3'd2;
    localparam logic [2:0] CLR_ORANGE = 3'd3;
    localparam logic [2:0] CLR_BLUE   = 3'd4;
    localparam logic [2:0] CLR_GREEN  = 3'd5;
    localparam logic [2:0] CLR_CYAN   = 3'd6;

    // link status codes
    localparam logic [1:0] LINK_DISCONNECTED = 2'd0;
    localparam logic [1:0] LINK_ADVERTISING  = 2'd1;
    localparam logic [1:0] LINK_CONNECTED    = 2'd2;

    // breathe steps and ceilings
    localparam logic [STEP_W-1:0] STEP_FAST = 8'd51;
    localparam logic [STEP_W-1:0] STEP_MID  = 8'd5;
    localparam logic [STEP_W-1:0] STEP_SLOW = 8'd1;
    localparam logic [STEP_W-1:0] MAX_HIGH  = 8'd255;
    localparam logic [STEP_W-1:0] MAX_LOW   = 8'd50;
    localparam logic [7:0]        LEVEL_FULL = 8'd255;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [1:0]        ble_status;
        logic              error_on;
        logic              homing_on;
        logic              wifi_setup_on;
        logic              update_on;
        logic              comm_pulse;
    } item_t;

    typedef struct packed {
        logic       show_rainbow;
        logic [2:0] color_code;
        logic [7:0] level;
        logic [7:0] hue;
    } result_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0] breathe_interval_ms;
        logic [TIMEOUT_W-1:0]  adv_timeout_ms;
    } cfg_t;

endpackage

`default_nettype wire

### design/slbs_ifs.sv
// ----------------------------------------------------------------------------
// slbs_ifs: valid/ready channels of the status LED breathe sequencer
// Poll channel carries one poll beat, LED channel carries one result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface slbs_poll_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic [1:0]  ble_status;
    logic        error_on;
    logic        homing_on;
    logic        wifi_setup_on;
    logic        update_on;
    logic        comm_pulse;

    modport source (
        output valid, now_ms, ble_status, error_on, homing_on, wifi_setup_on,
               update_on, comm_pulse,
        input  ready
    );
    modport sink (
        input  valid, now_ms, ble_status, error_on, homing_on, wifi_setup_on,
               update_on, comm_pulse,
        output ready
    );
endinterface

interface slbs_led_if;
    logic       valid;
    logic       ready;
    logic       show_rainbow;
    logic [2:0] color_code;
    logic [7:0] level;
    logic [7:0] hue;

    modport source (
        output valid, show_rainbow, color_code, level, hue,
        input  ready
    );
    modport sink (
        input  valid, show_rainbow, color_code, level, hue,
        output ready
    );
endinterface

`default_nettype wire

### design/slbs_hue.sv
// ----------------------------------------------------------------------------
// slbs_hue: hue of the rainbow sweep
// Scale elapsed time to 0..254 as elapsed * 255 / RAINBOW_MS by reciprocal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slbs_hue #(
    parameter int RAINBOW_MS = slbs_pkg::RAINBOW_MS_DEFAULT
) (
    input  wire logic [$clog2(RAINBOW_MS+1)-1:0] elapsed,
    output logic [7:0]                           hue
);
    import slbs_pkg::*;

    localparam int ELAPSED_W = $clog2(RAINBOW_MS + 1);
    // shift of 2*ELAPSED_W keeps the rounded-up reciprocal exact for
    // every elapsed value below RAINBOW_MS
    localparam int SHIFT  = 2 * ELAPSED_W;
    localparam int MULT_W = SHIFT + 8;
    localparam int PROD_W = ELAPSED_W + MULT_W;
    localparam logic [63:0] MULT_WIDE =
        ((64'd255 << SHIFT) + 64'(RAINBOW_MS) - 64'd1) / 64'(RAINBOW_MS);
    localparam logic [MULT_W-1:0] MULT_C = MULT_W'(MULT_WIDE);

    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(elapsed) * PROD_W'(MULT_C);
    assign hue  = prod[SHIFT +: 8];

endmodule

`default_nettype wire

### design/slbs_core.sv
// ----------------------------------------------------------------------------
// slbs_core: decision logic and state of the breathe sequencer
// Pick color, step and ceiling, run link logic, sweep and breathe step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slbs_core #(
    parameter int RAINBOW_MS = slbs_pkg::RAINBOW_MS_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire slbs_pkg::item_t item,
    input  wire slbs_pkg::cfg_t  cfg,
    output logic                 has_result,
    output slbs_pkg::result_t    result
);
    import slbs_pkg::*;

    localparam int ELAPSED_W = $clog2(RAINBOW_MS + 1);

    logic signed [LEVEL_W-1:0] level_reg, level_next;
    logic                      rising_reg, rising_next;
    logic [TIME_W-1:0]         last_step_reg, last_step_next;
    logic [1:0]                seen_reg, seen_next;
    logic                      rainbow_on_reg, rainbow_on_next;
    logic [TIME_W-1:0]         rainbow_start_reg, rainbow_start_next;
    logic [TIME_W-1:0]         adv_start_reg, adv_start_next;
    logic                      dimmed_reg, dimmed_next;
    logic                      pending_reg, pending_next;

    logic                      pend;
    logic                      any_flag;
    logic                      link_chg;
    logic                      link_live;
    logic                      rb;
    logic [TIME_W-1:0]         rs;
    logic [TIME_W-1:0]         as_time;
    logic                      dim;
    logic                      adv_late;
    logic [TIME_W-1:0]         elapsed;
    logic                      sweep_live;
    logic                      step_due;
    logic [7:0]                hue;
    logic                      do_breathe;
    logic [2:0]                color;
    logic [STEP_W-1:0]         step;
    logic [STEP_W-1:0]         ceil_lv;
    logic signed [LEVEL_W-1:0] step_s;
    logic signed [LEVEL_W-1:0] ceil_s;
    logic signed [LEVEL_W-1:0] level_new;

    // link state as it stands after this beat's status sample
    assign pend      = pending_reg | item.comm_pulse;
    assign any_flag  = item.error_on | item.homing_on | item.wifi_setup_on | item.update_on;
    assign link_chg  = item.ble_status != seen_reg;
    assign link_live = (item.ble_status == LINK_ADVERTISING)
                     || (item.ble_status == LINK_CONNECTED);
    assign rb        = link_chg ? link_live : rainbow_on_reg;
    assign rs        = (link_chg && link_live) ? item.now_ms : rainbow_start_reg;
    assign as_time   = (link_chg && item.ble_status == LINK_ADVERTISING)
                     ? item.now_ms : adv_start_reg;
    assign adv_late  = (item.now_ms - as_time) >= TIME_W'(cfg.adv_timeout_ms);
    assign dim       = (link_chg ? 1'b0 : dimmed_reg)
                     | ((item.ble_status == LINK_ADVERTISING) && !rb && adv_late);
    assign elapsed    = item.now_ms - rs;
    assign sweep_live = elapsed < TIME_W'(RAINBOW_MS);
    assign step_due   = (item.now_ms - last_step_reg) > TIME_W'(cfg.breathe_interval_ms);

    slbs_hue #(
        .RAINBOW_MS (RAINBOW_MS)
    ) u_hue (
        .elapsed (elapsed[ELAPSED_W-1:0]),
        .hue     (hue)
    );

    always_comb
    begin
        level_next         = level_reg;
        rising_next        = rising_reg;
        last_step_next     = last_step_reg;
        seen_next          = seen_reg;
        rainbow_on_next    = rainbow_on_reg;
        rainbow_start_next = rainbow_start_reg;
        adv_start_next     = adv_start_reg;
        dimmed_next        = dimmed_reg;
        pending_next       = pend;
        has_result         = 1'b0;
        result             = '0;
        do_breathe         = 1'b0;
        color              = CLR_CYAN;
        step               = STEP_SLOW;
        ceil_lv            = MAX_LOW;
        level_new          = level_reg;

        if (any_flag)
        begin
            do_breathe = 1'b1;
            ceil_lv    = MAX_HIGH;
            if (item.error_on)
            begin
                color = CLR_RED;
                step  = STEP_FAST;
            end
            else if (item.homing_on)
            begin
                color = CLR_PURPLE;
                step  = STEP_MID;
            end
            else if (item.wifi_setup_on)
            begin
                color = CLR_YELLOW;
                step  = STEP_MID;
            end
            else
            begin
                color = CLR_ORANGE;
                step  = STEP_FAST;
            end
        end
        else
        begin
            seen_next          = item.ble_status;
            rainbow_on_next    = rb;
            rainbow_start_next = rs;
            adv_start_next     = as_time;
            dimmed_next        = dim;
            if (link_live && rb)
            begin
                if (sweep_live)
                begin
                    has_result          = 1'b1;
                    result.show_rainbow = 1'b1;
                    result.hue          = hue;
                end
                else
                begin
                    rainbow_on_next = 1'b0;
                end
            end
            else
            begin
                do_breathe = 1'b1;
                case (item.ble_status)
                    LINK_ADVERTISING:
                    begin
                        color   = CLR_BLUE;
                        step    = dim ? STEP_SLOW : STEP_MID;
                        ceil_lv = dim ? MAX_LOW : MAX_HIGH;
                    end
                    LINK_CONNECTED:
                    begin
                        color = CLR_GREEN;
                    end
                    default:
                    begin
                        color = CLR_CYAN;
                    end
                endcase
            end
        end

        step_s = $signed(LEVEL_W'(step));
        ceil_s = $signed(LEVEL_W'(ceil_lv));

        if (do_breathe && step_due)
        begin
            last_step_next = item.now_ms;
            if (rising_reg)
            begin
                level_new = level_reg + step_s;
                if (level_new >= ceil_s)
                begin
                    rising_next = 1'b0;
                end
            end
            else
            begin
                level_new = level_reg - step_s;
                if (level_new <= $signed(LEVEL_W'(0)))
                begin
                    rising_next = 1'b1;
                end
            end
            level_next        = level_new;
            has_result        = 1'b1;
            result.color_code = color;
            if (pend)
            begin
                pending_next = 1'b0;
                result.level = LEVEL_FULL;
            end
            else if (level_new < $signed(LEVEL_W'(0)))
            begin
                result.level = '0;
            end
            else if (level_new > $signed(LEVEL_W'(LEVEL_FULL)))
            begin
                result.level = LEVEL_FULL;
            end
            else
            begin
                result.level = level_new[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg         <= '0;
            rising_reg        <= 1'b1;
            last_step_reg     <= '0;
            seen_reg          <= LINK_DISCONNECTED;
            rainbow_on_reg    <= 1'b0;
            rainbow_start_reg <= '0;
            adv_start_reg     <= '0;
            dimmed_reg        <= 1'b0;
            pending_reg       <= 1'b0;
        end
        else if (advance)
        begin
            level_reg         <= level_next;
            rising_reg        <= rising_next;
            last_step_reg     <= last_step_next;
            seen_reg          <= seen_next;
            rainbow_on_reg    <= rainbow_on_next;
            rainbow_start_reg <= rainbow_start_next;
            adv_start_reg     <= adv_start_next;
            dimmed_reg        <= dimmed_next;
            pending_reg       <= pending_next;
        end
    end

endmodule

`default_nettype wire

### design/status_led_breathe_sequencer.sv
// ----------------------------------------------------------------------------
// status_led_breathe_sequencer: status LED color, breathe level and hue
// Flow: a poll beat waits in the input register, its result beat in the
//   result register. Throughput: one poll beat per cycle unless the LED
//   side stalls; the single pass between the two registers holds the sweep
//   multiplier and the 32-bit time compares.
// Reset: all state and configuration return to defaults at once, no sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module status_led_breathe_sequencer #(
    parameter int RAINBOW_MS = slbs_pkg::RAINBOW_MS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    slbs_poll_if.sink                            poll,
    slbs_led_if.source                           led,
    input  wire logic                            wr_en,
    input  wire logic [slbs_pkg::CFG_INDEX_W-1:0] wr_index,
    input  wire logic [slbs_pkg::CFG_DATA_W-1:0]  wr_data
);
    import slbs_pkg::*;

    // configuration registers
    logic [INTERVAL_W-1:0] interval_reg;
    logic [TIMEOUT_W-1:0]  timeout_reg;
    cfg_t                  cfg;

    // input register stage
    logic                  in_valid_reg;
    item_t                 item_reg;

    // result register stage
    logic                  out_valid_reg;
    result_t               out_reg;

    logic                  out_free;
    logic                  advance;
    logic                  core_has;
    result_t               core_res;
    logic                  poll_fire;

    // Result register can load when empty or being drained this cycle.
    assign out_free  = !out_valid_reg || led.ready;
    // Retire the held poll beat whenever the result side has room.
    assign advance   = in_valid_reg && out_free;
    assign poll.ready = !in_valid_reg || out_free;
    assign poll_fire = poll.valid && poll.ready;

    assign cfg.breathe_interval_ms = interval_reg;
    assign cfg.adv_timeout_ms      = timeout_reg;

    // Configuration writes: take the low bits that each register needs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RESET;
            timeout_reg  <= ADV_TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_BREATHE_INTERVAL: interval_reg <= wr_data[INTERVAL_W-1:0];
                CFG_ADV_TIMEOUT:      timeout_reg  <= wr_data[TIMEOUT_W-1:0];
                default:              ;
            endcase
        end
    end

    // Input stage: capture a poll beat, drop the valid once it is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (poll_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_fire)
        begin
            item_reg.now_ms        <= poll.now_ms;
            item_reg.ble_status    <= poll.ble_status;
            item_reg.error_on      <= poll.error_on;
            item_reg.homing_on     <= poll.homing_on;
            item_reg.wifi_setup_on <= poll.wifi_setup_on;
            item_reg.update_on     <= poll.update_on;
            item_reg.comm_pulse    <= poll.comm_pulse;
        end
    end

    // Decision logic and sequencer state; state advances with the beat.
    slbs_core #(
        .RAINBOW_MS (RAINBOW_MS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item       (item_reg),
        .cfg        (cfg),
        .has_result (core_has),
        .result     (core_res)
    );

    // Result stage: hold a beat until taken; polls without a result leave
    // nothing behind.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && core_has;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= core_res;
        end
    end

    assign led.valid        = out_valid_reg;
    assign led.show_rainbow = out_reg.show_rainbow;
    assign led.color_code   = out_reg.color_code;
    assign led.level        = out_reg.level;
    assign led.hue          = out_reg.hue;

endmodule

`default_nettype wire

### test/slbs_led_checker.sv
// ----------------------------------------------------------------------------
// slbs_led_checker: scoreboard for the status LED breathe sequencer
// Watches the poll and LED channels and the register write port, keeps its
// own copy of the breathe, sweep and link state, and compares every LED beat
// field by field with the oldest result it expects.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slbs_led_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    slbs_poll_if                             poll,
    slbs_led_if                              led,
    input  logic                             wr_en,
    input  logic [slbs_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [slbs_pkg::CFG_DATA_W-1:0]  wr_data,
    output int                               fail_count,
    output int                               due_count,
    output int                               led_beats
);
    import slbs_pkg::*;

    // mirrored registers
    logic [INTERVAL_W-1:0]     interval_ms;
    logic [TIMEOUT_W-1:0]      timeout_ms;

    // mirrored block state
    logic signed [LEVEL_W-1:0] level_now;
    logic                      rising;
    logic [TIME_W-1:0]         last_step_ms;
    logic [1:0]                seen_link;
    logic                      sweep_on;
    logic [TIME_W-1:0]         sweep_start_ms;
    logic [TIME_W-1:0]         adv_start_ms;
    logic                      dimmed;
    logic                      pulse_due;

    result_t                   due_leds [$];
    result_t                   want;
    result_t                   got;
    result_t                   made;
    item_t                     beat;
    bit                        made_one;

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // Step the shared triangle level when the interval has run out.
    task automatic breathe_step(input logic [TIME_W-1:0] now, input logic [2:0] color,
                                input int step, input int ceiling,
                                output bit hit, output result_t r);
        logic [TIME_W-1:0] gap;
        int                v;
        hit = 1'b0;
        r   = '0;
        gap = now - last_step_ms;
        if (gap > TIME_W'(interval_ms))
        begin
            hit          = 1'b1;
            last_step_ms = now;
            v            = level_now;
            if (rising)
            begin
                v = v + step;
                if (v >= ceiling)
                    rising = 1'b0;
            end
            else
            begin
                v = v - step;
                if (v <= 0)
                    rising = 1'b1;
            end
            level_now    = v[LEVEL_W-1:0];
            r.color_code = color;
            if (pulse_due)
            begin
                pulse_due = 1'b0;
                r.level   = LEVEL_FULL;
            end
            else if (v < 0)
                r.level = 8'd0;
            else if (v > 255)
                r.level = 8'd255;
            else
                r.level = v[7:0];
        end
    endtask

    task automatic hue_sweep(input logic [TIME_W-1:0] now, output bit hit, output result_t r);
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] h;
        hit     = 1'b0;
        r       = '0;
        elapsed = now - sweep_start_ms;
        if (elapsed < TIME_W'(RAINBOW_MS_DEFAULT))
        begin
            h              = (elapsed * 32'd255) / TIME_W'(RAINBOW_MS_DEFAULT);
            hit            = 1'b1;
            r.show_rainbow = 1'b1;
            r.hue          = h[7:0];
        end
        else
            sweep_on = 1'b0;
    endtask

    task automatic link_led(input logic [TIME_W-1:0] now, input logic [1:0] link,
                            output bit hit, output result_t r);
        if (link != seen_link)
        begin
            seen_link = link;
            sweep_on  = 1'b0;
            dimmed    = 1'b0;
            if (link == LINK_ADVERTISING || link == LINK_CONNECTED)
            begin
                sweep_on       = 1'b1;
                sweep_start_ms = now;
            end
            if (link == LINK_ADVERTISING)
                adv_start_ms = now;
        end
        if (link == LINK_ADVERTISING)
        begin
            if (sweep_on)
                hue_sweep(now, hit, r);
            else
            begin
                if (now - adv_start_ms >= TIME_W'(timeout_ms))
                    dimmed = 1'b1;
                if (dimmed)
                    breathe_step(now, CLR_BLUE, STEP_SLOW, MAX_LOW, hit, r);
                else
                    breathe_step(now, CLR_BLUE, STEP_MID, MAX_HIGH, hit, r);
            end
        end
        else if (link == LINK_CONNECTED)
        begin
            if (sweep_on)
                hue_sweep(now, hit, r);
            else
                breathe_step(now, CLR_GREEN, STEP_SLOW, MAX_LOW, hit, r);
        end
        else
            breathe_step(now, CLR_CYAN, STEP_SLOW, MAX_LOW, hit, r);
    endtask

    // Work out the LED beat, if any, that one poll beat causes.
    task automatic poll_to_led(input item_t p, output bit hit, output result_t r);
        if (p.comm_pulse)
            pulse_due = 1'b1;
        if (p.error_on)
            breathe_step(p.now_ms, CLR_RED, STEP_FAST, MAX_HIGH, hit, r);
        else if (p.homing_on)
            breathe_step(p.now_ms, CLR_PURPLE, STEP_MID, MAX_HIGH, hit, r);
        else if (p.wifi_setup_on)
            breathe_step(p.now_ms, CLR_YELLOW, STEP_MID, MAX_HIGH, hit, r);
        else if (p.update_on)
            breathe_step(p.now_ms, CLR_ORANGE, STEP_FAST, MAX_HIGH, hit, r);
        else
            link_led(p.now_ms, p.ble_status, hit, r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_ms    = INTERVAL_RESET;
            timeout_ms     = ADV_TIMEOUT_RESET;
            level_now      = '0;
            rising         = 1'b1;
            last_step_ms   = '0;
            seen_link      = LINK_DISCONNECTED;
            sweep_on       = 1'b0;
            sweep_start_ms = '0;
            adv_start_ms   = '0;
            dimmed         = 1'b0;
            pulse_due      = 1'b0;
            due_leds.delete();
            fail_count     = 0;
            due_count      = 0;
            led_beats      = 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    CFG_BREATHE_INTERVAL: interval_ms = wr_data[INTERVAL_W-1:0];
                    CFG_ADV_TIMEOUT:      timeout_ms  = wr_data[TIMEOUT_W-1:0];
                    default:              ;
                endcase
            end
            if (led.valid && led.ready)
            begin
                led_beats++;
                got.show_rainbow = led.show_rainbow;
                got.color_code   = led.color_code;
                got.level        = led.level;
                got.hue          = led.hue;
                if (due_leds.size() == 0)
                begin
                    $error("LED beat with nothing expected: rainbow %0d color %0d level %0d hue %0d",
                           got.show_rainbow, got.color_code, got.level, got.hue);
                    fail_count++;
                end
                else
                begin
                    want = due_leds.pop_front();
                    check_field("show_rainbow", want.show_rainbow, got.show_rainbow);
                    check_field("color_code", want.color_code, got.color_code);
                    check_field("level", want.level, got.level);
                    check_field("hue", want.hue, got.hue);
                end
            end
            if (poll.valid && poll.ready)
            begin
                beat.now_ms        = poll.now_ms;
                beat.ble_status    = poll.ble_status;
                beat.error_on      = poll.error_on;
                beat.homing_on     = poll.homing_on;
                beat.wifi_setup_on = poll.wifi_setup_on;
                beat.update_on     = poll.update_on;
                beat.comm_pulse    = poll.comm_pulse;
                poll_to_led(beat, made_one, made);
                if (made_one)
                    due_leds.push_back(made);
            end
            due_count = due_leds.size();
        end
    end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: top level test of the status LED breathe sequencer
// Drives poll beats with random gaps and LED back-pressure, rewrites both
// registers between phases, and leaves all checking to slbs_led_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import slbs_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int LATENCY_CYCLES  = 4;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 305;

    // status flag masks, packed as {error, homing, wifi setup, update}
    localparam logic [3:0] FLAG_NONE   = 4'b0000;
    localparam logic [3:0] FLAG_ERROR  = 4'b1000;
    localparam logic [3:0] FLAG_HOMING = 4'b0100;
    localparam logic [3:0] FLAG_WIFI   = 4'b0010;
    localparam logic [3:0] FLAG_UPDATE = 4'b0001;
    localparam logic [3:0] FLAG_ALL    = 4'b1111;

    // link code with no meaning; the block treats it as disconnected
    localparam logic [1:0] LINK_UNUSED = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;

    slbs_poll_if poll_ch ();
    slbs_led_if  led_ch ();

    int fail_count;
    int due_count;
    int led_beats;
    int poll_beats;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;

    // stimulus state: running millisecond time, sticky link code and flags
    logic [TIME_W-1:0]     clock_ms;
    logic [1:0]            link_now;
    logic [3:0]            flags_now;
    logic [INTERVAL_W-1:0] interval_now;

    // register settings per random phase, extremes first
    int interval_set [RANDOM_PHASES] = '{0, 1000, 10, 3, 500, 1};
    int timeout_set  [RANDOM_PHASES] = '{0, 600000, 200, 1000, 5000, 50};

    status_led_breathe_sequencer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .poll     (poll_ch),
        .led      (led_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    slbs_led_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .poll       (poll_ch),
        .led        (led_ch),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .fail_count (fail_count),
        .due_count  (due_count),
        .led_beats  (led_beats)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stop a hung run; the limit is far above the slowest legal run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // LED side: stall at random, at the rate the current phase asks for.
    initial
    begin
        led_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            led_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic item_t make_poll(input logic [TIME_W-1:0] now, input logic [1:0] link,
                                        input logic [3:0] flags, input logic pulse);
        item_t p;
        p.now_ms        = now;
        p.ble_status    = link;
        p.error_on      = flags[3];
        p.homing_on     = flags[2];
        p.wifi_setup_on = flags[1];
        p.update_on     = flags[0];
        p.comm_pulse    = pulse;
        return p;
    endfunction

    // Offer one poll beat and hold it until the block takes it. Enter and
    // leave at a falling edge; valid stays high for a back-to-back beat.
    task automatic send_poll(input item_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            poll_ch.valid <= 1'b0;
            @(negedge clk);
        end
        poll_ch.valid         <= 1'b1;
        poll_ch.now_ms        <= p.now_ms;
        poll_ch.ble_status    <= p.ble_status;
        poll_ch.error_on      <= p.error_on;
        poll_ch.homing_on     <= p.homing_on;
        poll_ch.wifi_setup_on <= p.wifi_setup_on;
        poll_ch.update_on     <= p.update_on;
        poll_ch.comm_pulse    <= p.comm_pulse;
        @(posedge clk);
        while (!poll_ch.ready)
            @(posedge clk);
        poll_beats++;
        @(negedge clk);
    endtask

    // Drop valid, wait for every expected LED beat, then let any beat that
    // makes no result clear the pipeline.
    task automatic wait_idle();
        poll_ch.valid <= 1'b0;
        while (due_count != 0)
            @(negedge clk);
        repeat (LATENCY_CYCLES) @(negedge clk);
    endtask

    // Write one register; only call while the block is idle.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val[CFG_DATA_W-1:0];
        if (idx == CFG_BREATHE_INTERVAL)
            interval_now = val[INTERVAL_W-1:0];
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // One random poll beat. Time mostly advances by steps around the
    // breathe interval so the level and sweeps progress; now and then it
    // jumps far ahead (advertising timeout) or anywhere (wrap, noise).
    task automatic random_poll();
        int    pick;
        logic  pulse;
        pick = $urandom_range(99);
        if (pick < 2)
            clock_ms = $urandom();
        else if (pick < 5)
            clock_ms = clock_ms + $urandom_range(700000);
        else
            clock_ms = clock_ms + $urandom_range(2 * interval_now + 3);
        if ($urandom_range(99) < 4)
            link_now = 2'($urandom_range(3));
        if ($urandom_range(99) < 5)
            flags_now = $urandom_range(1) ? FLAG_NONE : 4'($urandom_range(15));
        pulse = ($urandom_range(19) == 0);
        send_poll(make_poll(clock_ms, link_now, flags_now, pulse));
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        wr_en                 = 1'b0;
        wr_index              = CFG_BREATHE_INTERVAL;
        wr_data               = '0;
        poll_ch.valid         = 1'b0;
        poll_ch.now_ms        = '0;
        poll_ch.ble_status    = LINK_DISCONNECTED;
        poll_ch.error_on      = 1'b0;
        poll_ch.homing_on     = 1'b0;
        poll_ch.wifi_setup_on = 1'b0;
        poll_ch.update_on     = 1'b0;
        poll_ch.comm_pulse    = 1'b0;
        send_idle_pct         = 25;
        recv_stall_pct        = 57;
        poll_beats            = 0;
        clock_ms              = '0;
        link_now              = LINK_DISCONNECTED;
        flags_now             = FLAG_NONE;
        interval_now          = INTERVAL_RESET;

        // Hold reset, then release it at a falling edge.
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset register values.
        // Same time as reset: no step, no beat.
        send_poll(make_poll(32'd0, LINK_DISCONNECTED, FLAG_NONE, 1'b0));
        // Interval just passed: first cyan step.
        send_poll(make_poll(32'd11, LINK_DISCONNECTED, FLAG_NONE, 1'b0));
        // Each machine flag alone, the first one with a pulse.
        send_poll(make_poll(32'd100, LINK_DISCONNECTED, FLAG_ERROR, 1'b1));
        send_poll(make_poll(32'd200, LINK_DISCONNECTED, FLAG_ERROR, 1'b0));
        send_poll(make_poll(32'd300, LINK_DISCONNECTED, FLAG_HOMING, 1'b0));
        send_poll(make_poll(32'd400, LINK_DISCONNECTED, FLAG_WIFI, 1'b0));
        send_poll(make_poll(32'd500, LINK_DISCONNECTED, FLAG_UPDATE, 1'b0));
        // All flags at once: error wins, link is not looked at.
        send_poll(make_poll(32'd600, LINK_ADVERTISING, FLAG_ALL, 1'b0));
        // Advertising starts a sweep: first hue, last hue, sweep end.
        send_poll(make_poll(32'd700, LINK_ADVERTISING, FLAG_NONE, 1'b0));
        send_poll(make_poll(32'd1699, LINK_ADVERTISING, FLAG_NONE, 1'b0));
        send_poll(make_poll(32'd1700, LINK_ADVERTISING, FLAG_NONE, 1'b0));
        // Advertising blue, then dimmed after the timeout.
        send_poll(make_poll(32'd1800, LINK_ADVERTISING, FLAG_NONE, 1'b0));
        send_poll(make_poll(32'd40000, LINK_ADVERTISING, FLAG_NONE, 1'b0));
        // Connected: sweep, sweep end, green.
        send_poll(make_poll(32'd40100, LINK_CONNECTED, FLAG_NONE, 1'b0));
        send_poll(make_poll(32'd41200, LINK_CONNECTED, FLAG_NONE, 1'b0));
        send_poll(make_poll(32'd41300, LINK_CONNECTED, FLAG_NONE, 1'b0));
        // Unused link code, then back to disconnected.
        send_poll(make_poll(32'd41400, LINK_UNUSED, FLAG_NONE, 1'b0));
        send_poll(make_poll(32'd41500, LINK_DISCONNECTED, FLAG_NONE, 1'b0));
        // Time wrap, with a pulse that waits out an item without a step.
        send_poll(make_poll(32'hFFFF_FFF0, LINK_DISCONNECTED, FLAG_NONE, 1'b0));
        send_poll(make_poll(32'h0000_0005, LINK_DISCONNECTED, FLAG_NONE, 1'b1));
        send_poll(make_poll(32'h0000_0005, LINK_DISCONNECTED, FLAG_NONE, 1'b1));
        send_poll(make_poll(32'h0000_0010, LINK_DISCONNECTED, FLAG_NONE, 1'b0));
        // Sweep running across the time wrap.
        send_poll(make_poll(32'hFFFF_FF00, LINK_ADVERTISING, FLAG_NONE, 1'b0));
        send_poll(make_poll(32'h0000_0100, LINK_ADVERTISING, FLAG_NONE, 1'b0));
        // Every field at its top value.
        send_poll(make_poll(32'hFFFF_FFFF, LINK_UNUSED, FLAG_ALL, 1'b1));
        clock_ms = 32'h0000_0200;
        link_now = LINK_ADVERTISING;
        wait_idle();

        // Random phases: new register values each time, idling patterns
        // sender-light, then receiver-light, then none at all.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph < 2)
            begin
                send_idle_pct  = 25;
                recv_stall_pct = 57;
            end
            else if (ph < 4)
            begin
                send_idle_pct  = 57;
                recv_stall_pct = 25;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            write_reg(CFG_BREATHE_INTERVAL, interval_set[ph]);
            write_reg(CFG_ADV_TIMEOUT, timeout_set[ph]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                random_poll();
                // Now and then hold off until the LED side has caught up.
                if ($urandom_range(149) == 0)
                    wait_idle();
            end
            wait_idle();
        end

        $display("Run covered %0d poll beats and %0d LED beats over %0d register settings,",
                 poll_beats, led_beats, RANDOM_PHASES + 1);
        $display("with every status flag, all link codes, pulses, hue sweeps and time wrap.");
        if (fail_count == 0 && due_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
